### src/ptrrs_pkg.sv
// ----------------------------------------------------------------------------
// ptrrs_pkg
// Shared codes and field widths of the periodic task round-robin scheduler.
// ----------------------------------------------------------------------------
package ptrrs_pkg;

  // fixed field widths of the input and result words
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned STATUS_W = 2;

  // action codes of an input word
  typedef enum logic [ACTION_W-1:0] {
    ACT_STEP    = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_DISABLE = 2'd2
  } action_e;

  // status codes of a result word
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BAD_ID = 2'd2
  } status_e;

endpackage

### src/ptrrs_in_if.sv
// ----------------------------------------------------------------------------
// ptrrs_in_if
// Input channel of the scheduler: valid/ready handshake and one command word.
// ----------------------------------------------------------------------------
interface ptrrs_in_if
  import ptrrs_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) ();

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [TIME_BITS-1:0] now_ms;
  logic [TIME_BITS-1:0] period_ms;
  logic [ID_W-1:0]      entry_id;

  modport source (
    output valid, action, now_ms, period_ms, entry_id,
    input  ready
  );

  modport sink (
    input  valid, action, now_ms, period_ms, entry_id,
    output ready
  );

endinterface

### src/ptrrs_out_if.sv
// ----------------------------------------------------------------------------
// ptrrs_out_if
// Result channel of the scheduler: valid/ready handshake and one result word.
// ----------------------------------------------------------------------------
interface ptrrs_out_if
  import ptrrs_pkg::*;
();

  logic                valid;
  logic                ready;
  logic                fired;
  logic [ID_W-1:0]     fired_id;
  logic [ID_W-1:0]     new_id;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, fired, fired_id, new_id, status,
    input  ready
  );

  modport sink (
    input  valid, fired, fired_id, new_id, status,
    output ready
  );

endinterface

### src/periodic_task_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_round_robin_scheduler
// Table of periodic tasks examined one entry per tick by a round-robin cursor.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries command words (step, add, disable) on a valid/ready
//   handshake; out_o returns exactly one result word per command.
//   Periods and last fire times live in two synchronous memories of
//   MAX_SCHEDULES entries; enable bits, entry count and cursor are flops.
//   Timing: add, disable and a step on an empty table give their result
//   in the cycle after acceptance. A step reads the cursor's entry in the
//   acceptance cycle, evaluates and writes back the fire time in the next,
//   and its result word is registered at the end of that evaluation cycle.
//   Throughput: no new command is accepted while a step evaluates; add and
//   disable are accepted every cycle while the receiver takes each result.
//   A result word waits in an output register; a new command is accepted
//   in the same cycle the waiting word is taken.
//   Reset clears enable bits, entry count, cursor and the output register;
//   memory contents stay undefined and are only evaluated below the entry count.
//   A stalled receiver holds the result word and blocks further commands.
// ----------------------------------------------------------------------------
module periodic_task_round_robin_scheduler
  import ptrrs_pkg::*;
#(
  parameter int unsigned MAX_SCHEDULES = 16,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptrrs_in_if.sink    in_i,
  ptrrs_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SCHEDULES + 1);
  localparam int unsigned IDX_W = (MAX_SCHEDULES > 1) ? $clog2(MAX_SCHEDULES) : 1;
  localparam int unsigned CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  // control and result registers
  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         cursor_q, cursor_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [MAX_SCHEDULES-1:0] en_q, en_d;
  logic [TIME_BITS-1:0]     now_q, now_d;
  logic                     out_valid_q, out_valid_d;
  logic                     fired_q, fired_d;
  logic [ID_W-1:0]          fired_id_q, fired_id_d;
  logic [ID_W-1:0]          new_id_q, new_id_d;
  status_e                  status_q, status_d;

  // table memories
  logic [TIME_BITS-1:0] period_mem [MAX_SCHEDULES];
  logic [TIME_BITS-1:0] last_mem   [MAX_SCHEDULES];
  logic [TIME_BITS-1:0] period_rd_q;
  logic [TIME_BITS-1:0] last_rd_q;

  logic                 accept;
  action_e              act;
  logic                 full;
  logic                 id_bad;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     id_ext;
  logic [CMP_W-1:0]     cur_ext;
  logic [CNT_W-1:0]     cur_inc;
  logic [TIME_BITS-1:0] elapsed;
  logic                 fire;
  logic                 add_wr;
  logic                 last_we;
  logic [IDX_W-1:0]     last_waddr;
  logic [TIME_BITS-1:0] last_wdata;

  // handshake
  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign act        = action_e'(in_i.action);

  // table checks
  assign cnt_ext = CMP_W'(count_q);
  assign id_ext  = CMP_W'(in_i.entry_id);
  assign cur_ext = CMP_W'(cursor_q);
  assign full    = (count_q == CNT_W'(MAX_SCHEDULES));
  assign id_bad  = (id_ext >= cnt_ext);
  assign cur_inc = CNT_W'(cursor_q) + CNT_W'(1);

  // fire decision on the entry read at the cursor
  assign elapsed = now_q - last_rd_q;
  assign fire    = en_q[cursor_q] &&
                   ((last_rd_q == '0) || (elapsed >= period_rd_q));

  // memory write ports
  assign add_wr     = accept && (act == ACT_ADD) && !full;
  assign last_we    = add_wr || ((state_q == S_EVAL) && fire);
  assign last_waddr = add_wr ? count_q[IDX_W-1:0] : cursor_q;
  assign last_wdata = add_wr ? '0 : now_q;

  always_ff @(posedge clk_i) begin
    if (add_wr) begin
      period_mem[count_q[IDX_W-1:0]] <= in_i.period_ms;
    end
    period_rd_q <= period_mem[cursor_q];
  end

  always_ff @(posedge clk_i) begin
    if (last_we) begin
      last_mem[last_waddr] <= last_wdata;
    end
    last_rd_q <= last_mem[cursor_q];
  end

  // next state and result word
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    en_d        = en_q;
    now_d       = now_q;
    out_valid_d = out_valid_q && !out_o.ready;
    fired_d     = fired_q;
    fired_id_d  = fired_id_q;
    new_id_d    = new_id_q;
    status_d    = status_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          fired_d     = 1'b0;
          fired_id_d  = '0;
          new_id_d    = '0;
          status_d    = STAT_OK;
          unique case (act)
            ACT_STEP: begin
              if (count_q == '0) begin
                status_d = STAT_BAD_ID;
              end else begin
                // memory read of the cursor entry is under way
                out_valid_d = 1'b0;
                now_d       = in_i.now_ms;
                state_d     = S_EVAL;
              end
            end
            ACT_ADD: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                en_d[count_q[IDX_W-1:0]] = 1'b1;
                new_id_d                 = cnt_ext[ID_W-1:0];
                count_d                  = count_q + CNT_W'(1);
                cursor_d                 = '0;
              end
            end
            ACT_DISABLE: begin
              if (id_bad) begin
                status_d = STAT_BAD_ID;
              end else begin
                en_d[id_ext[IDX_W-1:0]] = 1'b0;
              end
            end
            default: begin
              // unused action code: all-zero result
            end
          endcase
        end
      end
      S_EVAL: begin
        out_valid_d = 1'b1;
        fired_d     = fire;
        fired_id_d  = fire ? cur_ext[ID_W-1:0] : '0;
        cursor_d    = (cur_inc >= count_q) ? '0 : cur_inc[IDX_W-1:0];
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      count_q     <= '0;
      en_q        <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
      fired_q     <= 1'b0;
      fired_id_q  <= '0;
      new_id_q    <= '0;
      status_q    <= STAT_OK;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      en_q        <= en_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
      fired_q     <= fired_d;
      fired_id_q  <= fired_id_d;
      new_id_q    <= new_id_d;
      status_q    <= status_d;
    end
  end

  // result channel
  assign out_o.valid    = out_valid_q;
  assign out_o.fired    = fired_q;
  assign out_o.fired_id = fired_id_q;
  assign out_o.new_id   = new_id_q;
  assign out_o.status   = status_q;

endmodule

### src/ptrrs_checker.sv
// ----------------------------------------------------------------------------
// ptrrs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ptrrs_checker
  import ptrrs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic [ACTION_W-1:0] in_action_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                out_fired_i,
  input logic [ID_W-1:0]     out_fired_id_i,
  input logic [ID_W-1:0]     out_new_id_i,
  input logic [STATUS_W-1:0] out_status_i
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_fired_i) &&
      $stable(out_fired_id_i) && $stable(out_new_id_i) && $stable(out_status_i))
    else $error("result word changed while stalled");

  // an accepted add gives its result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_ADD) |=>
      out_valid_i && !out_fired_i &&
      ((out_status_i == STAT_OK) || (out_status_i == STAT_FULL)))
    else $error("add result missing or malformed");

  // only a good step fires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_fired_i |-> (out_status_i == STAT_OK) && (out_new_id_i == '0))
    else $error("fire reported with bad status or new id");

  // fired id is zero when nothing fired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_fired_i |-> (out_fired_id_i == '0))
    else $error("fired id set without fire");

endmodule

bind periodic_task_round_robin_scheduler ptrrs_checker u_ptrrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_action_i    (in_i.action),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_fired_i    (out_o.fired),
  .out_fired_id_i (out_o.fired_id),
  .out_new_id_i   (out_o.new_id),
  .out_status_i   (out_o.status)
);
